[hw/rtl/lac_pkg.sv]
// Shared types and constants for the LRU address cache.
// Used by lac_cell, lac_select and lru_address_cache; no dependencies.
`default_nettype none
package lac_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned Entries  = 64;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_INSERT = 1'b1
  } func_e;

  // One stored entry; the position in the cell chain is its recency rank.
  typedef struct packed {
    logic                valid;
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } entry_t;

  // Result of the most-recent-match selection.
  typedef struct packed {
    logic                hit;
    logic [PayloadW-1:0] payload;
  } sel_t;

endpackage
`default_nettype wire

[hw/rtl/lac_cell.sv]
// One cell of the recency chain: holds one entry and a registered key compare.
// Depends on lac_pkg.
`default_nettype none
module lac_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmp_en_i,
  input  wire logic [lac_pkg::KeyW-1:0]  cmp_key_i,
  input  wire logic                      shift_en_i,
  input  wire lac_pkg::entry_t           left_i,
  output lac_pkg::entry_t                ent_o,
  output logic                           match_o
);

  logic                         valid_q;
  logic [lac_pkg::KeyW-1:0]     key_q;
  logic [lac_pkg::PayloadW-1:0] payload_q;
  logic                         match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (shift_en_i) begin
        valid_q <= left_i.valid;
      end
      if (cmp_en_i) begin
        match_q <= valid_q && (key_q == cmp_key_i);
      end
    end
  end

  // take the neighbor's entry, moving one step toward least recent
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      key_q     <= left_i.key;
      payload_q <= left_i.payload;
    end
  end

  assign ent_o   = '{valid: valid_q, key: key_q, payload: payload_q};
  assign match_o = match_q;

endmodule
`default_nettype wire

[hw/rtl/lac_select.sv]
// Picks the most recent matching cell, selects its payload and marks the
// cells that shift on a hit. Depends on lac_pkg.
`default_nettype none
module lac_select #(
  parameter int unsigned ENTRIES = lac_pkg::Entries
) (
  input  wire logic [ENTRIES-1:0] match_i,
  input  wire lac_pkg::entry_t    ent_i [ENTRIES],
  output logic [ENTRIES-1:0]      take_o,
  output logic [ENTRIES-1:0]      first_o,
  output lac_pkg::sel_t           sel_o
);

  logic [ENTRIES-1:0]           none_before;
  logic [lac_pkg::PayloadW-1:0] payload;

  always_comb begin
    payload = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      none_before[i] = ~|(match_i & ~({ENTRIES{1'b1}} << i));
      first_o[i]     = match_i[i] & none_before[i];
      payload        = payload | ({lac_pkg::PayloadW{first_o[i]}} & ent_i[i].payload);
    end
  end

  // on a hit, cells from the front up to the matching one shift
  assign take_o = none_before & {ENTRIES{|match_i}};
  assign sel_o  = '{hit: |match_i, payload: payload};

endmodule
`default_nettype wire

[hw/rtl/lru_address_cache.sv]
// Top level of the LRU address cache: input/output stream stages, the cell
// chain and the selection logic. Depends on lac_pkg, lac_cell, lac_select.
`default_nettype none
// The cache keeps ENTRIES entries in a chain of cells ordered by recency: cell 0
// is the most recent entry and the last cell the least recent. In the cycle an item
// is accepted every cell compares its key with the item's key; when the item then
// leaves its holding stage the most recent match is picked, the result is registered
// and the chain shifts (insert: all cells shift and the new entry enters cell 0,
// dropping the least recent one when full; hit: the matched entry moves to cell 0).
// The next item is accepted in the cycle after that, so a new item is not taken
// while one is still held. A lookup waits while the output register holds a result
// that is not taken. Inserts give no result; a lookup always gives one, with tdata
// zero on a miss. No clearing pass is needed after reset.
module lru_address_cache #(
  parameter int unsigned ENTRIES = lac_pkg::Entries
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [63:0] key_address, [127:64] entry_data
  input  wire logic [lac_pkg::KeyW+lac_pkg::PayloadW-1:0] s_axis_tdata_i,
  // [0] func
  input  wire logic                              s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [63:0] found_data
  output logic [lac_pkg::PayloadW-1:0]           m_axis_tdata_o,
  // [0] hit
  output logic                                   m_axis_tuser_o
);

  logic                         s1_valid_q;
  lac_pkg::func_e               s1_func_q;
  logic [lac_pkg::KeyW-1:0]     s1_key_q;
  logic [lac_pkg::PayloadW-1:0] s1_data_q;

  logic                         out_valid_q;
  logic                         out_hit_q;
  logic [lac_pkg::PayloadW-1:0] out_data_q;

  logic                         in_fire;
  logic                         s2_fire;
  logic                         s2_lookup;
  logic [lac_pkg::KeyW-1:0]     in_key;

  lac_pkg::entry_t              ent   [ENTRIES];
  lac_pkg::entry_t              left  [ENTRIES];
  logic [ENTRIES-1:0]           match;
  logic [ENTRIES-1:0]           take;
  logic [ENTRIES-1:0]           first;
  logic [ENTRIES-1:0]           shift_en;
  lac_pkg::sel_t                sel;
  lac_pkg::entry_t              front;

  assign in_key          = s_axis_tdata_i[lac_pkg::KeyW-1:0];
  assign s_axis_tready_o = !s1_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s2_lookup       = (s1_func_q == lac_pkg::FUNC_LOOKUP);
  // a lookup waits for room in the output register; an insert never does
  assign s2_fire         = s1_valid_q && (!s2_lookup || !out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_fire && s2_lookup) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= lac_pkg::func_e'(s_axis_tuser_i);
      s1_key_q  <= in_key;
      s1_data_q <= s_axis_tdata_i[lac_pkg::KeyW +: lac_pkg::PayloadW];
    end
    if (s2_fire && s2_lookup) begin
      out_hit_q  <= sel.hit;
      out_data_q <= sel.payload;
    end
  end

  // entry that enters cell 0: the new entry or the one that just hit
  always_comb begin
    unique case (s1_func_q)
      lac_pkg::FUNC_INSERT: front = '{valid: 1'b1, key: s1_key_q, payload: s1_data_q};
      lac_pkg::FUNC_LOOKUP: front = '{valid: 1'b1, key: s1_key_q, payload: sel.payload};
      default:              front = '{valid: 1'b1, key: s1_key_q, payload: s1_data_q};
    endcase
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left[i] = front;
    end else begin : g_body
      assign left[i] = ent[i-1];
    end
    assign shift_en[i] = s2_fire && (s2_lookup ? take[i] : 1'b1);

    lac_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_en_i   (in_fire),
      .cmp_key_i  (in_key),
      .shift_en_i (shift_en[i]),
      .left_i     (left[i]),
      .ent_o      (ent[i]),
      .match_o    (match[i])
    );
  end

  lac_select #(
    .ENTRIES (ENTRIES)
  ) u_select (
    .match_i (match),
    .ent_i   (ent),
    .take_o  (take),
    .first_o (first),
    .sel_o   (sel)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_hit_q;

  logic [ENTRIES-1:0] valid_vec;
  for (genvar i = 0; i < ENTRIES; i++) begin : g_valid
    assign valid_vec[i] = ent[i].valid;
  end

  // occupied cells always form a run from the front of the chain
  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("gap in occupied cells");

  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first))
    else $error("more than one most recent match");

  a_hit_from_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s2_lookup) |=> (m_axis_tvalid_o && (m_axis_tuser_o == $past(|match))))
    else $error("lookup result does not follow the compare");

  a_insert_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && !s2_lookup && !out_valid_q) |=> !m_axis_tvalid_o)
    else $error("insert produced a result");

endmodule
`default_nettype wire
